### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked property, disabled while reset is high
`define MMQE_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property, checked during reset as well
`define MMQE_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MMQE_ASSERT(name, clk, rst, prop, msg)
`define MMQE_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

### rtl/mmqe_pkg.sv
// ---------------------------------------------------------------------------
// Multi-mode queue engine package
// Payload types, codes and controller/datapath interface structs.
// ---------------------------------------------------------------------------
package mmqe_pkg;

   localparam int MMQE_DEPTH      = 16;
   localparam int MMQE_DATA_WIDTH = 32;
   localparam int ITEM_DATA_WIDTH = 32;
   localparam int PRIO_WIDTH      = 8;
   localparam int COUNT_OUT_WIDTH = 5;

   // Request opcodes
   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_DEQUEUE = 1'b1;

   // Ordering modes; the unused code behaves as fifo
   typedef enum logic [1:0] {
      MODE_FIFO     = 2'd0,
      MODE_LIFO     = 2'd1,
      MODE_PRIORITY = 2'd2
   } mode_type;

   // Response status codes
   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic                       opcode;
      logic [ITEM_DATA_WIDTH-1:0] item_data;
      logic [PRIO_WIDTH-1:0]      item_priority;
   } req_type;

   typedef struct packed {
      logic [1:0]                 status;
      logic [ITEM_DATA_WIDTH-1:0] out_data;
      logic [PRIO_WIDTH-1:0]      out_priority;
      logic [COUNT_OUT_WIDTH-1:0] entry_count_out;
   } rsp_type;

   // Memory read address sources
   typedef enum logic [1:0] {
      RD_HEAD      = 2'd0,
      RD_SCAN_NEXT = 2'd1,
      RD_SHIFT_SRC = 2'd2
   } rd_sel_type;

   // Memory write address sources
   typedef enum logic [1:0] {
      WR_TAIL      = 2'd0,
      WR_HEAD_PREV = 2'd1,
      WR_INSERT    = 2'd2,
      WR_SHIFT_DST = 2'd3
   } wr_sel_type;

   typedef struct packed {
      logic       accept;
      logic       eval;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_en;
      wr_sel_type wr_sel;
      logic       head_inc;
      logic       head_dec;
      logic       tail_inc;
      logic       count_inc;
      logic       count_dec;
      logic       scan_init;
      logic       scan_inc;
      logic       pos_from_scan;
      logic       pos_from_count;
      logic       shift_init;
      logic       shift_dec;
      logic       load_rsp;
   } cmd_type;

   typedef struct packed {
      logic       op_dequeue;
      logic       empty;
      logic       full;
      logic [1:0] mode;
      logic       scan_hit;
      logic       scan_last;
      logic       shift_last;
      logic       rsp_busy;
   } sts_type;

endpackage

### rtl/mmqe_ctrl.sv
// ---------------------------------------------------------------------------
// Queue engine controller
// Sequences accept, evaluation, priority scan, entry shift and response.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mmqe_ctrl
   import mmqe_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_EXEC     = 8'b0000_0010,
      ST_DEQ_DATA = 8'b0000_0100,
      ST_SCAN     = 8'b0000_1000,
      ST_SHIFT_RD = 8'b0001_0000,
      ST_SHIFT_WR = 8'b0010_0000,
      ST_INSERT   = 8'b0100_0000,
      ST_DONE     = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Hold off requests while one is in progress
   assign req_stall = (state_ff != ST_IDLE);

   // Next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.eval = 1'b1;
            if (sts.op_dequeue) begin
               if (sts.empty) begin
                  state_in = ST_DONE;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RD_HEAD;
                  state_in   = ST_DEQ_DATA;
               end
            end else if (sts.full) begin
               state_in = ST_DONE;
            end else begin
               case (sts.mode)
                  MODE_LIFO: begin
                     cmd.wr_en     = 1'b1;
                     cmd.wr_sel    = WR_HEAD_PREV;
                     cmd.head_dec  = 1'b1;
                     cmd.count_inc = 1'b1;
                     state_in      = ST_DONE;
                  end
                  MODE_PRIORITY: begin
                     if (sts.empty) begin
                        cmd.pos_from_count = 1'b1;
                        state_in           = ST_INSERT;
                     end else begin
                        cmd.rd_en     = 1'b1;
                        cmd.rd_sel    = RD_HEAD;
                        cmd.scan_init = 1'b1;
                        state_in      = ST_SCAN;
                     end
                  end
                  default: begin
                     cmd.wr_en     = 1'b1;
                     cmd.wr_sel    = WR_TAIL;
                     cmd.tail_inc  = 1'b1;
                     cmd.count_inc = 1'b1;
                     state_in      = ST_DONE;
                  end
               endcase
            end
         end
         ST_DEQ_DATA: begin
            cmd.head_inc  = 1'b1;
            cmd.count_dec = 1'b1;
            state_in      = ST_DONE;
         end
         ST_SCAN: begin
            // Read the next entry while comparing the current one
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_SCAN_NEXT;
            if (sts.scan_hit) begin
               cmd.pos_from_scan = 1'b1;
               cmd.shift_init    = 1'b1;
               state_in          = ST_SHIFT_RD;
            end else if (sts.scan_last) begin
               cmd.pos_from_count = 1'b1;
               state_in           = ST_INSERT;
            end else begin
               cmd.scan_inc = 1'b1;
            end
         end
         ST_SHIFT_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_SHIFT_SRC;
            state_in   = ST_SHIFT_WR;
         end
         ST_SHIFT_WR: begin
            cmd.wr_en     = 1'b1;
            cmd.wr_sel    = WR_SHIFT_DST;
            cmd.shift_dec = 1'b1;
            state_in      = sts.shift_last ? ST_INSERT : ST_SHIFT_RD;
         end
         ST_INSERT: begin
            cmd.wr_en     = 1'b1;
            cmd.wr_sel    = WR_INSERT;
            cmd.tail_inc  = 1'b1;
            cmd.count_inc = 1'b1;
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            if (!sts.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Advance state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `MMQE_ASSERT(a_scan_nonempty, clock, reset, (state_ff == ST_SCAN || state_ff == ST_SHIFT_RD) |-> !sts.empty, "scan or shift on an empty queue")
   `MMQE_ASSERT(a_done_release, clock, reset, (state_ff == ST_DONE && !sts.rsp_busy) |=> (state_ff == ST_IDLE && !req_stall), "response not released")

endmodule

### rtl/mmqe_datapath.sv
// ---------------------------------------------------------------------------
// Queue engine datapath
// Entry memory, head/tail/count pointers, scan and shift indexes, response.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mmqe_datapath
   import mmqe_pkg::*;
#(
   parameter int DEPTH      = MMQE_DEPTH,
   parameter int DATA_WIDTH = MMQE_DATA_WIDTH
)
(
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   output sts_type    sts,
   input  req_type    req_payload,
   input  logic [1:0] csr_data,
   input  logic       csr_write,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_payload
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int EW = DATA_WIDTH + PRIO_WIDTH;

   logic [EW-1:0]  entry_mem_ff [DEPTH];
   logic [EW-1:0]  rd_data_ff;
   logic [1:0]     mode_ff;
   logic [AW-1:0]  head_ff;
   logic [AW-1:0]  tail_ff;
   logic [CW-1:0]  count_ff;
   req_type        req_ff;
   logic [1:0]     status_ff;
   logic [CW-1:0]  scan_idx_ff;
   logic [CW-1:0]  pos_ff;
   logic [CW-1:0]  ptr_ff;
   logic           rsp_valid_ff;
   rsp_type        rsp_ff;

   logic [AW-1:0]  head_next;
   logic [AW-1:0]  head_prev;
   logic [AW-1:0]  tail_next;
   logic [AW-1:0]  rd_addr;
   logic [AW-1:0]  wr_addr;
   logic [EW-1:0]  wr_data;
   logic [EW-1:0]  new_entry;
   logic [PRIO_WIDTH-1:0] rd_prio;
   logic [DATA_WIDTH-1:0] rd_word;
   logic [1:0]     status_in;
   logic           deq_ok;
   rsp_type        rsp_in;

   // Slot at an offset from a base, wrapped once modulo DEPTH
   function automatic logic [AW-1:0] slot_at(logic [AW-1:0] base, logic [CW-1:0] off);
      logic [CW:0] sum;
      sum = (CW+1)'(base) + (CW+1)'(off);
      if (sum >= (CW+1)'(DEPTH)) begin
         sum = sum - (CW+1)'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   assign head_next = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + AW'(1);
   assign head_prev = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - AW'(1);
   assign tail_next = (tail_ff == AW'(DEPTH - 1)) ? '0 : tail_ff + AW'(1);

   assign rd_prio   = rd_data_ff[EW-1 -: PRIO_WIDTH];
   assign rd_word   = rd_data_ff[DATA_WIDTH-1:0];
   assign new_entry = {req_ff.item_priority, DATA_WIDTH'(req_ff.item_data)};

   // Select memory addresses
   always_comb begin
      case (cmd.rd_sel)
         RD_HEAD:      rd_addr = head_ff;
         RD_SCAN_NEXT: rd_addr = slot_at(head_ff, scan_idx_ff + CW'(1));
         RD_SHIFT_SRC: rd_addr = slot_at(head_ff, ptr_ff - CW'(1));
         default:      rd_addr = head_ff;
      endcase
      case (cmd.wr_sel)
         WR_TAIL:      wr_addr = tail_ff;
         WR_HEAD_PREV: wr_addr = head_prev;
         WR_INSERT:    wr_addr = slot_at(head_ff, pos_ff);
         WR_SHIFT_DST: wr_addr = slot_at(head_ff, ptr_ff);
         default:      wr_addr = tail_ff;
      endcase
      wr_data = (cmd.wr_sel == WR_SHIFT_DST) ? rd_data_ff : new_entry;
   end

   // Entry memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         entry_mem_ff[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= entry_mem_ff[rd_addr];
      end
   end

   // Mode register and queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_FIFO;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (csr_write) begin
            mode_ff <= csr_data;
         end
         if (cmd.head_inc) begin
            head_ff <= head_next;
         end else if (cmd.head_dec) begin
            head_ff <= head_prev;
         end
         if (cmd.tail_inc) begin
            tail_ff <= tail_next;
         end
         if (cmd.count_inc) begin
            count_ff <= count_ff + CW'(1);
         end else if (cmd.count_dec) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

   // Evaluate the request against the current fill level
   always_comb begin
      if (req_ff.opcode == OP_DEQUEUE) begin
         status_in = (count_ff == '0) ? STATUS_EMPTY : STATUS_DONE;
      end else begin
         status_in = (count_ff == CW'(DEPTH)) ? STATUS_FULL : STATUS_DONE;
      end
   end

   // Latch request, status and scan/shift indexes
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff <= req_payload;
      end
      if (cmd.eval) begin
         status_ff <= status_in;
      end
      if (cmd.scan_init) begin
         scan_idx_ff <= '0;
      end else if (cmd.scan_inc) begin
         scan_idx_ff <= scan_idx_ff + CW'(1);
      end
      if (cmd.pos_from_scan) begin
         pos_ff <= scan_idx_ff;
      end else if (cmd.pos_from_count) begin
         pos_ff <= count_ff;
      end
      if (cmd.shift_init) begin
         ptr_ff <= count_ff;
      end else if (cmd.shift_dec) begin
         ptr_ff <= ptr_ff - CW'(1);
      end
   end

   // Status toward the controller
   assign sts.op_dequeue = (req_ff.opcode == OP_DEQUEUE);
   assign sts.empty      = (count_ff == '0);
   assign sts.full       = (count_ff == CW'(DEPTH));
   assign sts.mode       = mode_ff;
   assign sts.scan_hit   = (rd_prio < req_ff.item_priority);
   assign sts.scan_last  = (scan_idx_ff + CW'(1) == count_ff);
   assign sts.shift_last = (ptr_ff - CW'(1) == pos_ff);
   assign sts.rsp_busy   = rsp_valid_ff && rsp_stall;

   // Build the response
   assign deq_ok = (req_ff.opcode == OP_DEQUEUE) && (status_ff == STATUS_DONE);
   always_comb begin
      rsp_in.status          = status_ff;
      rsp_in.out_data        = deq_ok ? ITEM_DATA_WIDTH'(rd_word) : '0;
      rsp_in.out_priority    = deq_ok ? rd_prio : '0;
      rsp_in.entry_count_out = COUNT_OUT_WIDTH'(count_ff);
   end

   // Output register: load on command, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `MMQE_ASSERT(a_rsp_from_load, clock, reset, $rose(rsp_valid_ff) |-> $past(cmd.load_rsp), "response appeared without a load")
   `MMQE_ASSERT(a_write_not_full, clock, reset, cmd.wr_en |-> (count_ff < CW'(DEPTH)), "entry written while queue full")
   `MMQE_ASSERT(a_empty_rsp, clock, reset, (rsp_valid_ff && rsp_ff.status == STATUS_EMPTY) |-> (rsp_ff.entry_count_out == '0 && rsp_ff.out_data == '0), "empty response carries data")

endmodule

### rtl/multi_mode_queue_engine_unit.sv
// ---------------------------------------------------------------------------
// Multi-mode queue engine
// Bounded fifo / lifo / priority queue of DEPTH entries with one result
// per enqueue or dequeue request.
//
//   Channel  Direction  Handshake          Payload
//   req_     in         valid / stall      req_type (opcode, data, priority)
//   rsp_     out        valid / stall      rsp_type (status, data, prio, count)
//   csr_     in         valid / ready      ordering mode select (2 bits)
//
// One request at a time. Fifo, lifo, full and empty-dequeue requests load
// their result after evaluation, a dequeue that returns an entry after the
// head read; a priority enqueue scans, moves each displaced entry by a read
// and a write, then inserts, all through the single read and single write
// port of the entry memory. The next request can be taken the cycle after the load.
// Reset is synchronous and clears pointers, count and mode; memory has no reset.
// A stalled result holds in the output register and keeps the next request
// from finishing, but the next request is already accepted.
// ---------------------------------------------------------------------------
module multi_mode_queue_engine_unit
   import mmqe_pkg::*;
#(
   parameter int DEPTH      = MMQE_DEPTH,
   parameter int DATA_WIDTH = MMQE_DATA_WIDTH
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_payload,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_payload,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_data
);

   cmd_type cmd;
   sts_type sts;

   // Mode writes are taken at any time
   assign csr_ready = 1'b1;

   mmqe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   mmqe_datapath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_payload (req_payload),
      .csr_data    (csr_data),
      .csr_write   (csr_valid && csr_ready),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
